FILE: hdl/lpc_pkg.sv
// lpc_pkg: shared types, constants and helpers of the 3x3 low-pass convolution
// no dependencies; taken in by scoped names from every module but lpc_line_mem

package lpc_pkg;

  localparam int PIXEL_W        = 8;
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int MASK_W     = 2;
  localparam int POS_W      = 10;

  localparam int SIZE_MIN     = 3;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // weighted sum peaks at 1 + 16 * 255
  localparam int SUM_W = 12;

  // floor(s / d) as (s * ceil(2^16 / d)) >> 16, exact for s below 2^12
  localparam int RECIP_W        = 13;
  localparam int RECIP_SHIFT    = 16;
  localparam int RECIP_NINE     = 7282;
  localparam int RECIP_TEN      = 6554;
  localparam int BINOMIAL_SHIFT = 4;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [POS_W-1:0]   pos_field_t;

  typedef enum logic [MASK_W-1:0] {
    MASK_BOX      = 2'd0,
    MASK_CENTRE   = 2'd1,
    MASK_BINOMIAL = 2'd2
  } mask_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASK   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // position of one accepted pixel and its border flags
  typedef struct packed {
    pos_field_t row;
    pos_field_t row_above;
    pos_field_t col;
    pos_field_t col_left;
    logic       row_ge1;
    logic       row_ge2;
    logic       col_ge1;
    logic       col_ge2;
    logic       col_last;
    logic       row_last;
  } pos_t;

  // window taps that leave unchanged on the border
  typedef struct packed {
    pixel_t centre;
    pixel_t right;
    pixel_t below;
    pixel_t corner;
  } taps_t;

  typedef struct packed {
    pixel_t     value;
    pos_field_t row;
    pos_field_t col;
    logic       frame_end;
  } result_t;

  // last index of a frame dimension after clamping to [SIZE_MIN, hi]
  function automatic int unsigned size_last(input logic [CFG_DATA_W-1:0] v,
                                            input int unsigned hi);
    int unsigned s;
    if (int'(v) < SIZE_MIN) begin
      s = SIZE_MIN;
    end else if (int'(v) > int'(hi)) begin
      s = hi;
    end else begin
      s = int'(v);
    end
    return s - 1;
  endfunction

endpackage

FILE: hdl/lpc_line_mem.sv
// lpc_line_mem: line store RAM, one write port and one registered read port
// depends on nothing; the top level packs both stored rows into one word

module lpc_line_mem #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 16
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data holds while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/lpc_window.sv
// lpc_window: 3x3 window registers and the registered weighted sum
// depends on lpc_pkg for pixel, mask and tap types

module lpc_window (
  input  logic                        clk_i,
  input  logic                        advance_i,
  input  logic                        shift_i,
  input  lpc_pkg::pixel_t             top_i,
  input  lpc_pkg::pixel_t             mid_i,
  input  lpc_pkg::pixel_t             pixel_i,
  input  lpc_pkg::mask_e              mask_i,
  output logic [lpc_pkg::SUM_W-1:0]   sum_o,
  output lpc_pkg::taps_t              taps_o
);

  localparam int SW = lpc_pkg::SUM_W;

  lpc_pkg::pixel_t  win_q [9];
  logic [SW-1:0]    corners;
  logic [SW-1:0]    edges;
  logic [SW-1:0]    centre;
  logic [SW-1:0]    sum_d;
  logic [SW-1:0]    sum_q;
  lpc_pkg::taps_t   taps_d;
  lpc_pkg::taps_t   taps_q;

  // row-major window, new column enters on the right
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int k = 0; k < 3; k++) begin
        win_q[3*k]   <= win_q[3*k+1];
        win_q[3*k+1] <= win_q[3*k+2];
      end
      win_q[2] <= top_i;
      win_q[5] <= mid_i;
      win_q[8] <= pixel_i;
    end
  end

  always_comb begin
    corners = SW'(win_q[0]) + SW'(win_q[2]) + SW'(win_q[6]) + SW'(win_q[8]);
    edges   = SW'(win_q[1]) + SW'(win_q[3]) + SW'(win_q[5]) + SW'(win_q[7]);
    centre  = SW'(win_q[4]);
    case (mask_i)
      lpc_pkg::MASK_CENTRE:   sum_d = SW'(1) + corners + edges + (centre << 1);
      lpc_pkg::MASK_BINOMIAL: sum_d = SW'(1) + corners + (edges << 1) + (centre << 2);
      default:                sum_d = SW'(1) + corners + edges + centre;
    endcase
    taps_d.centre = win_q[4];
    taps_d.right  = win_q[5];
    taps_d.below  = win_q[7];
    taps_d.corner = win_q[8];
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      sum_q  <= sum_d;
      taps_q <= taps_d;
    end
  end

  assign sum_o  = sum_q;
  assign taps_o = taps_q;

endmodule

FILE: hdl/lpc_divide.sv
// lpc_divide: floored division of the window sum by 9, 10 or 16
// depends on lpc_pkg for reciprocal constants and tap types

module lpc_divide (
  input  logic                        clk_i,
  input  logic                        advance_i,
  input  lpc_pkg::mask_e              mask_i,
  input  logic [lpc_pkg::SUM_W-1:0]   sum_i,
  input  lpc_pkg::taps_t              taps_i,
  output lpc_pkg::pixel_t             quot_o,
  output lpc_pkg::taps_t              taps_o
);

  localparam int SW     = lpc_pkg::SUM_W;
  localparam int RW     = lpc_pkg::RECIP_W;
  localparam int PROD_W = SW + RW;
  localparam int QW     = PROD_W - lpc_pkg::RECIP_SHIFT;
  localparam int PW     = lpc_pkg::PIXEL_W;

  logic [RW-1:0]     recip;
  logic [PROD_W-1:0] product;
  logic [QW-1:0]     quot_wide;
  lpc_pkg::pixel_t   quot_d;
  lpc_pkg::pixel_t   quot_q;
  lpc_pkg::taps_t    taps_q;

  always_comb begin
    case (mask_i)
      lpc_pkg::MASK_CENTRE: recip = RW'(lpc_pkg::RECIP_TEN);
      default:              recip = RW'(lpc_pkg::RECIP_NINE);
    endcase
    product = PROD_W'(sum_i) * PROD_W'(recip);
    case (mask_i)
      lpc_pkg::MASK_BINOMIAL: quot_wide = QW'(sum_i[SW-1:lpc_pkg::BINOMIAL_SHIFT]);
      default:                quot_wide = product[PROD_W-1:lpc_pkg::RECIP_SHIFT];
    endcase
    if (quot_wide > QW'({PW{1'b1}})) begin
      quot_d = {PW{1'b1}};
    end else begin
      quot_d = quot_wide[PW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      quot_q <= quot_d;
      taps_q <= taps_i;
    end
  end

  assign quot_o = quot_q;
  assign taps_o = taps_q;

endmodule

FILE: hdl/lpc_emit.sv
// lpc_emit: expands each pixel into its zero to four results and buffers them
// depends on lpc_pkg for position, tap and result types

module lpc_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  output logic                 advance_o,
  input  logic                 valid_i,
  input  lpc_pkg::pos_t        pos_i,
  input  lpc_pkg::pixel_t      quot_i,
  input  lpc_pkg::taps_t       taps_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lpc_pkg::pixel_t      value_o,
  output lpc_pkg::pos_field_t  out_row_o,
  output lpc_pkg::pos_field_t  out_column_o,
  output logic                 frame_end_o
);

  localparam int BUF_DEPTH = 2;

  // pending results of the held pixel, lowest bit goes first
  logic [3:0]         pend_q;
  logic [3:0]         pend_d;
  logic [3:0]         pend_new;
  logic [3:0]         pend_sel;
  lpc_pkg::pos_t      pos_q;
  lpc_pkg::pixel_t    quot_q;
  lpc_pkg::taps_t     taps_q;
  lpc_pkg::result_t   res;

  lpc_pkg::result_t   buf_q [BUF_DEPTH];
  logic [1:0]         cnt_q;
  logic [1:0]         cnt_d;
  logic               rd_ptr_q;
  logic               wr_ptr_q;
  logic               not_full;
  logic               push;
  logic               pop;

  assign not_full  = (cnt_q != 2'(BUF_DEPTH));
  assign push      = (pend_q != 4'd0) && not_full;
  assign pop       = (cnt_q != 2'd0) && !out_stall_i;
  assign pend_sel  = pend_q & (~pend_q + 4'd1);
  // take the next pixel once at most its last result is leaving
  assign advance_o = (pend_q == 4'd0) ||
                     (((pend_q & (pend_q - 4'd1)) == 4'd0) && not_full);

  always_comb begin
    pend_new = {pos_i.row_last & pos_i.col_last,
                pos_i.row_last & pos_i.col_ge1,
                pos_i.row_ge1  & pos_i.col_last,
                pos_i.row_ge1  & pos_i.col_ge1};
    if (advance_o) begin
      pend_d = valid_i ? pend_new : 4'd0;
    end else if (push) begin
      pend_d = pend_q & ~pend_sel;
    end else begin
      pend_d = pend_q;
    end
  end

  always_comb begin
    res.frame_end = 1'b0;
    if (pend_q[0]) begin
      res.value = (pos_q.row_ge2 && pos_q.col_ge2) ? quot_q : taps_q.centre;
      res.row   = pos_q.row_above;
      res.col   = pos_q.col_left;
    end else if (pend_q[1]) begin
      res.value = taps_q.right;
      res.row   = pos_q.row_above;
      res.col   = pos_q.col;
    end else if (pend_q[2]) begin
      res.value = taps_q.below;
      res.row   = pos_q.row;
      res.col   = pos_q.col_left;
    end else begin
      res.value     = taps_q.corner;
      res.row       = pos_q.row;
      res.col       = pos_q.col;
      res.frame_end = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else begin
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      pos_q  <= pos_i;
      quot_q <= quot_i;
      taps_q <= taps_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  assign out_valid_o  = (cnt_q != 2'd0);
  assign value_o      = buf_q[rd_ptr_q].value;
  assign out_row_o    = buf_q[rd_ptr_q].row;
  assign out_column_o = buf_q[rd_ptr_q].col;
  assign frame_end_o  = buf_q[rd_ptr_q].frame_end;

endmodule

FILE: hdl/lowpass_3x3_convolution.sv
// lowpass_3x3_convolution: top level, position counters, configuration and pipeline
// depends on lpc_pkg, lpc_line_mem, lpc_window, lpc_divide and lpc_emit
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    pixel_i
//   result    out        out_valid_o / out_stall_i  value_o, out_row_o, out_column_o,
//                                                   frame_end_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one pixel per cycle while out_stall_i is low; the result port moves one request per cycle
// unless stalled, so a pixel with more than one result holds the input until only its last
// is left to buffer (last pixel of every row but the first, every pixel but the first on the
// last row, the final pixel of a frame). the first result passes the line read, window, sum,
// quotient, emit and buffer registers. the line stores are one RAM with one read and one write
// per pixel. reset clears counters, configuration and handshake state; no clearing pass.

module lowpass_3x3_convolution #(
  parameter int MAX_WIDTH  = lpc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lpc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  lpc_pkg::pixel_t                    pixel_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output lpc_pkg::pixel_t                    value_o,
  output lpc_pkg::pos_field_t                out_row_o,
  output lpc_pkg::pos_field_t                out_column_o,
  output logic                               frame_end_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int PW    = lpc_pkg::PIXEL_W;
  localparam int PSW   = lpc_pkg::POS_W;
  localparam logic [COL_W-1:0] W_LAST_RESET =
    COL_W'(lpc_pkg::size_last(lpc_pkg::CFG_DATA_W'(lpc_pkg::WIDTH_RESET), MAX_WIDTH));
  localparam logic [ROW_W-1:0] H_LAST_RESET =
    ROW_W'(lpc_pkg::size_last(lpc_pkg::CFG_DATA_W'(lpc_pkg::HEIGHT_RESET), MAX_HEIGHT));

  logic [lpc_pkg::MASK_W-1:0] mask_q;
  logic [COL_W-1:0]           w_last_q;
  logic [ROW_W-1:0]           h_last_q;
  lpc_pkg::mask_e             mask;

  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_eff;
  logic [ROW_W-1:0] row_eff;

  logic             advance;
  logic             accept;
  lpc_pkg::pos_t    pos0;

  // stages: 0 line read data, 1 window, 2 sum, 3 quotient
  logic [3:0]       stage_valid_q;
  lpc_pkg::pos_t    stage_pos_q [4];
  lpc_pkg::pixel_t  px_q;
  logic [COL_W-1:0] s1_col_q;

  logic [2*PW-1:0]  line_rd;
  lpc_pkg::pixel_t  top;
  lpc_pkg::pixel_t  mid;

  logic [lpc_pkg::SUM_W-1:0] sum;
  lpc_pkg::taps_t            sum_taps;
  lpc_pkg::pixel_t           quot;
  lpc_pkg::taps_t            quot_taps;

  assign mask        = lpc_pkg::mask_e'(mask_q);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q   <= lpc_pkg::MASK_BOX;
      w_last_q <= W_LAST_RESET;
      h_last_q <= H_LAST_RESET;
    end else if (cfg_valid_i) begin
      unique case (lpc_pkg::cfg_idx_e'(cfg_index_i))
        lpc_pkg::CFG_MASK:   mask_q   <= cfg_data_i[lpc_pkg::MASK_W-1:0];
        lpc_pkg::CFG_WIDTH:  w_last_q <= COL_W'(lpc_pkg::size_last(cfg_data_i, MAX_WIDTH));
        lpc_pkg::CFG_HEIGHT: h_last_q <= ROW_W'(lpc_pkg::size_last(cfg_data_i, MAX_HEIGHT));
        default: ;
      endcase
    end
  end

  // a counter left beyond a narrowed frame saturates to its last index
  assign col_eff = (col_q > w_last_q) ? w_last_q : col_q;
  assign row_eff = (row_q > h_last_q) ? h_last_q : row_q;

  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  always_comb begin
    pos0.row       = PSW'(row_eff);
    pos0.row_above = PSW'(row_eff - ROW_W'(1));
    pos0.col       = PSW'(col_eff);
    pos0.col_left  = PSW'(col_eff - COL_W'(1));
    pos0.row_ge1   = (row_eff != ROW_W'(0));
    pos0.row_ge2   = (row_eff >= ROW_W'(2));
    pos0.col_ge1   = (col_eff != COL_W'(0));
    pos0.col_ge2   = (col_eff >= COL_W'(2));
    pos0.col_last  = (col_eff == w_last_q);
    pos0.row_last  = (row_eff == h_last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      row_q         <= '0;
      stage_valid_q <= '0;
    end else if (advance) begin
      stage_valid_q <= {stage_valid_q[2:0], in_valid_i};
      if (in_valid_i) begin
        if (col_eff == w_last_q) begin
          col_q <= '0;
          row_q <= (row_eff == h_last_q) ? '0 : row_eff + ROW_W'(1);
        end else begin
          col_q <= col_eff + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stage_pos_q[0] <= pos0;
      for (int k = 1; k < 4; k++) begin
        stage_pos_q[k] <= stage_pos_q[k-1];
      end
      px_q     <= pixel_i;
      s1_col_q <= col_eff;
    end
  end

  // word holds {older row, newer row}; both move up one row on write-back
  assign top = line_rd[2*PW-1:PW];
  assign mid = line_rd[PW-1:0];

  lpc_line_mem #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (2 * PW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (col_eff),
    .rd_data_o (line_rd),
    .wr_en_i   (advance && stage_valid_q[0]),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({mid, px_q})
  );

  lpc_window u_window (
    .clk_i     (clk_i),
    .advance_i (advance),
    .shift_i   (advance && stage_valid_q[0]),
    .top_i     (top),
    .mid_i     (mid),
    .pixel_i   (px_q),
    .mask_i    (mask),
    .sum_o     (sum),
    .taps_o    (sum_taps)
  );

  lpc_divide u_divide (
    .clk_i     (clk_i),
    .advance_i (advance),
    .mask_i    (mask),
    .sum_i     (sum),
    .taps_i    (sum_taps),
    .quot_o    (quot),
    .taps_o    (quot_taps)
  );

  lpc_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_o    (advance),
    .valid_i      (stage_valid_q[3]),
    .pos_i        (stage_pos_q[3]),
    .quot_i       (quot),
    .taps_i       (quot_taps),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

FILE: tb/lowpass_3x3_convolution_test.sv
// lowpass_3x3_convolution_test: self-checking bench for the 3x3 low-pass convolution
// depends on lpc_pkg and lowpass_3x3_convolution; a directed table first, then random frames
// every result is checked against an in-bench line-store and window predictor

`timescale 1ns / 1ps

module lowpass_3x3_convolution_test;
  import lpc_pkg::*;

  localparam int          MAX_W          = MAX_WIDTH_DEF;
  localparam int          MAX_H          = MAX_HEIGHT_DEF;
  localparam int          CLK_HALF_NS    = 2;
  localparam int          RESET_CYCLES   = 5;
  localparam int          SETTLE_CYCLES  = 12;
  localparam int          DRAIN_LIMIT    = 5000;
  localparam int          RANDOM_ITEMS   = 320;
  localparam int          IDLE_PERCENT   = 14;
  localparam int          TIMEOUT_CYCLES = 400000;
  localparam int unsigned BOX_DIV        = 9;
  localparam int unsigned CENTRE_DIV     = 10;
  localparam int unsigned BINOMIAL_DIV   = 16;

  // index that maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef enum logic {STEP_REG, STEP_PIXEL} step_kind_e;

  typedef struct {
    step_kind_e             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    pixel_t                 px;
    bit                     typed;
    pixel_t                 typed_value;
  } step_t;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  pixel_t                pixel_i     = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pixel_t                value_o;
  pos_field_t            out_row_o;
  pos_field_t            out_column_o;
  logic                  frame_end_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  // predictor state
  pixel_t                upper_row  [MAX_W] = '{default: '0};
  pixel_t                lower_row  [MAX_W] = '{default: '0};
  bit                    upper_seen [MAX_W];
  bit                    lower_seen [MAX_W];
  pixel_t                win        [9]     = '{default: '0};
  int unsigned           col_pos    = 0;
  int unsigned           row_pos    = 0;
  logic [MASK_W-1:0]     mask_sel   = MASK_BOX;
  logic [CFG_DATA_W-1:0] width_reg  = CFG_DATA_W'(WIDTH_RESET);
  logic [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(HEIGHT_RESET);

  result_t pending_results [$];
  step_t   stim_table [$];
  int      last_emitted   = 0;
  int      mismatch_count = 0;
  int      random_sent    = 0;
  bit      quiet          = 1'b0;

  lowpass_3x3_convolution dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (value_o),
    .out_row_o    (out_row_o),
    .out_column_o (out_column_o),
    .frame_end_o  (frame_end_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF_NS);
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned clamp_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    int unsigned s;
    s = v;
    if (s < SIZE_MIN) return SIZE_MIN;
    if (s > hi) return hi;
    return s;
  endfunction

  function automatic int unsigned smooth_window();
    int unsigned corners, edges, centre;
    corners = win[0] + win[2] + win[6] + win[8];
    edges   = win[1] + win[3] + win[5] + win[7];
    centre  = win[4];
    case (mask_sel)
      MASK_CENTRE:   return (1 + corners + edges + 2 * centre) / CENTRE_DIV;
      MASK_BINOMIAL: return (1 + corners + 2 * edges + 4 * centre) / BINOMIAL_DIV;
      default:       return (1 + corners + edges + centre) / BOX_DIV;
    endcase
  endfunction

  function automatic void queue_result(int unsigned v, int unsigned r, int unsigned c,
                                       logic fe);
    result_t res;
    res.value     = pixel_t'(v);
    res.row       = pos_field_t'(r);
    res.col       = pos_field_t'(c);
    res.frame_end = fe;
    pending_results.push_back(res);
  endfunction

  // advances the frame position by one pixel and queues the samples it completes
  function automatic int convolve_pixel(pixel_t px);
    int unsigned w, h, r, c;
    pixel_t      top, mid;
    int          emitted;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    emitted = 0;
    // a size shrunk under the current position pulls the counters back
    if (col_pos > w - 1) col_pos = w - 1;
    if (row_pos > h - 1) row_pos = h - 1;
    r = row_pos;
    c = col_pos;
    top = upper_row[c];
    mid = lower_row[c];
    upper_row[c]  = mid;
    upper_seen[c] = lower_seen[c];
    lower_row[c]  = px;
    lower_seen[c] = 1'b1;
    for (int k = 0; k < 9; k += 3) begin
      win[k]   = win[k+1];
      win[k+1] = win[k+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    if (r >= 1 && c >= 1) begin
      queue_result((r >= 2 && c >= 2) ? smooth_window() : win[4], r - 1, c - 1, 1'b0);
      emitted++;
    end
    if (r >= 1 && c == w - 1) begin
      queue_result(win[5], r - 1, c, 1'b0);
      emitted++;
    end
    if (r == h - 1 && c >= 1) begin
      queue_result(win[7], r, c - 1, 1'b0);
      emitted++;
    end
    if (r == h - 1 && c == w - 1) begin
      queue_result(win[8], r, c, 1'b1);
      emitted++;
    end
    if (c == w - 1) begin
      col_pos = 0;
      row_pos = (r == h - 1) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return emitted;
  endfunction

  // true when both line stores hold data for every column below cols
  function automatic bit lines_hold(int unsigned cols);
    for (int unsigned k = 0; k < cols; k++) begin
      if (!(upper_seen[k] && lower_seen[k])) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s.kind  = STEP_REG;
    s.idx   = idx;
    s.data  = data;
    s.px    = '0;
    s.typed = 1'b0;
    s.typed_value = '0;
    stim_table.push_back(s);
  endfunction

  function automatic void add_pixel(pixel_t px, bit typed, pixel_t typed_value);
    step_t s;
    s.kind  = STEP_PIXEL;
    s.idx   = '0;
    s.data  = '0;
    s.px    = px;
    s.typed = typed;
    s.typed_value = typed_value;
    stim_table.push_back(s);
  endfunction

  task automatic wait_idle();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_MASK:   mask_sel   = data[MASK_W-1:0];
      CFG_WIDTH:  width_reg  = data;
      CFG_HEIGHT: height_reg = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // returns at the edge that takes the pixel, with valid still high
  task automatic send_pixel(pixel_t px);
    while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    last_emitted = convolve_pixel(px);
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %0d row %0d column %0d", value_o, out_row_o,
               out_column_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value) begin
          $error("value mismatch: expected %0d, got %0d", want.value, value_o);
          mismatch_count++;
        end
        if (out_row_o !== want.row) begin
          $error("out_row mismatch: expected %0d, got %0d", want.row, out_row_o);
          mismatch_count++;
        end
        if (out_column_o !== want.col) begin
          $error("out_column mismatch: expected %0d, got %0d", want.col, out_column_o);
          mismatch_count++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end mismatch: expected %0d, got %0d", want.frame_end, frame_end_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    int unsigned new_size;
    int unsigned pick;

    // spare index, mask code 3, widest frame cut short mid-row, tallest frame cut short mid-frame
    add_reg(CFG_IDX_SPARE, 11'h7ff);
    add_reg(CFG_MASK, CFG_DATA_W'(3));
    add_reg(CFG_WIDTH, 11'h7ff);
    add_reg(CFG_HEIGHT, 11'h7ff);
    repeat (4) add_pixel(8'hff, 1'b1, 8'hff);
    add_reg(CFG_WIDTH, '0);
    repeat (10) add_pixel(8'hff, 1'b1, 8'hff);
    add_reg(CFG_HEIGHT, CFG_DATA_W'(1));
    repeat (3) add_pixel(8'hff, 1'b1, 8'hff);
    // black frame, binomial then centre-weighted for the last row
    add_reg(CFG_MASK, CFG_DATA_W'(MASK_BINOMIAL));
    repeat (6) add_pixel(8'h00, 1'b1, 8'h00);
    add_reg(CFG_MASK, CFG_DATA_W'(MASK_CENTRE));
    repeat (3) add_pixel(8'h00, 1'b1, 8'h00);

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == STEP_REG) begin
        in_valid_i <= 1'b0;
        wait_idle();
        write_reg(stim_table[i].idx, stim_table[i].data);
      end else begin
        send_pixel(stim_table[i].px);
        if (stim_table[i].typed && last_emitted > 0) begin
          pending_results[pending_results.size() - last_emitted].value =
            stim_table[i].typed_value;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 1)) write_reg(CFG_MASK, CFG_DATA_W'($urandom_range(0, 3)));
      if ($urandom_range(0, 1)) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) new_size = $urandom_range(0, 2);
        else if (pick < 3) new_size = $urandom_range(17, 40);
        else new_size = $urandom_range(3, 16);
        write_reg(CFG_WIDTH, CFG_DATA_W'(new_size));
      end
      if ($urandom_range(0, 1)) write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_IDX_SPARE, CFG_DATA_W'($urandom_range(0, 2047)));
      end
      do begin
        // occasional mid-frame change, sender held off until the block has drained
        if ($urandom_range(0, 99) < 3) begin
          in_valid_i <= 1'b0;
          wait_idle();
          case ($urandom_range(0, 2))
            0: write_reg(CFG_MASK, CFG_DATA_W'($urandom_range(0, 3)));
            1: begin
              // widen only over columns both line stores already hold
              new_size = $urandom_range(0, 24);
              if (lines_hold(clamp_dim(CFG_DATA_W'(new_size), MAX_W))) begin
                write_reg(CFG_WIDTH, CFG_DATA_W'(new_size));
              end
            end
            default: write_reg(CFG_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
          endcase
        end
        if ($urandom_range(0, 9) < 2) begin
          send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00);
        end else begin
          send_pixel(pixel_t'($urandom_range(0, 255)));
        end
        random_sent++;
        quiet = (random_sent >= 120 && random_sent < 220);
      end while (!(row_pos == 0 && col_pos == 0));
      in_valid_i <= 1'b0;
    end

    for (int n = 0; n < DRAIN_LIMIT && pending_results.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatch_count += pending_results.size();
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/lpc_pkg.sv
hdl/lpc_line_mem.sv
hdl/lpc_window.sv
hdl/lpc_divide.sv
hdl/lpc_emit.sv
hdl/lowpass_3x3_convolution.sv
tb/lowpass_3x3_convolution_test.sv
